@@ rtl/ssc_pkg.sv @@
`default_nettype none
// Shared constants, types and functions of the Stanley steering controller.
package ssc_pkg;

   localparam int MAX_POINTS   = 1024;
   localparam int IDX_W        = $clog2(MAX_POINTS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ZW           = 20;

   localparam logic signed [17:0] PI_Q13          = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q13     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q13      = 18'sd51472;
   localparam logic signed [19:0] CORDIC_GAIN_Q15 = 20'sd19898;

   localparam logic [2:0] CSR_STEER_GAIN    = 3'd0;
   localparam logic [2:0] CSR_WHEELBASE     = 3'd1;
   localparam logic [2:0] CSR_VEHICLE_SPEED = 3'd2;
   localparam logic [2:0] CSR_STEER_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_PATH_POINTS   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT,
      ST_FRONT_MUL,
      ST_FRONT_ADD,
      ST_SCAN,
      ST_ERR_MUL,
      ST_ERR_SUB,
      ST_GAIN_MUL,
      ST_NORM,
      ST_VEC,
      ST_OUT
   } state_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] step);
      logic signed [ZW-1:0] v;
      case (step)
         4'd0:    v = 20'sd51472;
         4'd1:    v = 20'sd30385;
         4'd2:    v = 20'sd16055;
         4'd3:    v = 20'sd8150;
         4'd4:    v = 20'sd4091;
         4'd5:    v = 20'sd2047;
         4'd6:    v = 20'sd1024;
         4'd7:    v = 20'sd512;
         4'd8:    v = 20'sd256;
         4'd9:    v = 20'sd128;
         4'd10:   v = 20'sd64;
         4'd11:   v = 20'sd32;
         4'd12:   v = 20'sd16;
         4'd13:   v = 20'sd8;
         4'd14:   v = 20'sd4;
         default: v = 20'sd2;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/stanley_steering_controller_unit.sv @@
`default_nettype none
// Stanley steering controller: path table, nearest point search and steering command.
// A load transaction is taken while the controller is idle; the next one may follow at once.
// A query over N path points raises its result after the path scan (one read per cycle,
// four stage pipeline), two 16-step CORDIC loops and up to 17 normalizing shifts; an
// empty path skips these and goes straight to the output state.
// Reset restores the register defaults and clears the target index and control state.
module stanley_steering_controller_unit
   import ssc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mode,
   input  wire logic [9:0]         req_point_index,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [15:0] req_point_heading,
   input  wire logic signed [31:0] req_pose_x,
   input  wire logic signed [31:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [14:0]      rsp_steer_angle,
   output logic [9:0]              rsp_target_index,
   output logic signed [31:0]      rsp_cross_track_error,
   output logic                    rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   state_type state_ff, state_in;

   logic [15:0] gain_ff;
   logic [23:0] wheelbase_ff;
   logic [23:0] speed_ff;
   logic [13:0] limit_ff;
   logic [10:0] path_points_ff;

   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic signed [15:0] pose_hdg_ff;
   logic               empty_ff;

   logic signed [19:0]   rx_ff, ry_ff;
   logic signed [ZW-1:0] rz_ff;
   logic                 neg_ff;
   logic [STEP_W-1:0]    step_ff;
   logic signed [19:0]   cos_ff, sin_ff;
   logic signed [44:0]   wbc_ff, wbs_ff;
   logic signed [31:0]   fx_ff, fy_ff;

   logic [CNT_W-1:0]   issue_ff;
   logic               v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]   i1_ff, i2_ff, i3_ff;
   logic signed [32:0] dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic [31:0]        ax2_ff, ay2_ff;
   logic [63:0]        sqx3_ff, sqy3_ff;
   logic               best_found_ff;
   logic [64:0]        best_dist_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic signed [32:0] bdx_ff, bdy_ff;

   logic signed [52:0]  pxs_ff, pyc_ff;
   logic signed [31:0]  err_ff;
   logic signed [17:0]  te_ff;
   logic [IDX_W-1:0]    tgt_ff, last_target_ff;
   logic [47:0]         ym_ff;
   logic [31:0]         xm_ff;
   logic signed [33:0]  vx_ff, vy_ff;
   logic signed [ZW-1:0] vz_ff;
   logic signed [16:0]  td_mag_ff;

   logic                    rsp_valid_ff;
   logic signed [14:0]      rsp_steer_ff;
   logic [9:0]              rsp_target_ff;
   logic signed [31:0]      rsp_err_ff;
   logic                    rsp_status_ff;

   logic               req_fire, out_free, issue_en, scan_done;
   logic [CNT_W-1:0]   n_eff;
   logic [IDX_W-1:0]   rd_addr, tgt_sel;
   logic [31:0]        rd_x, rd_y;
   logic [15:0]        rd_h;
   logic               wr_en;
   logic signed [17:0] hw_a, hw_w, hw_f;
   logic               hw_neg;
   logic signed [19:0] rx_n, ry_n, cos_v, sin_v;
   logic signed [ZW-1:0] rz_n, vz_n;
   logic signed [33:0] vx_n, vy_n;
   logic signed [24:0] wb_s;
   logic signed [32:0] dx_v, dy_v;
   logic [64:0]        dist_v;
   logic signed [53:0] err_diff;
   logic signed [17:0] hd_raw, hd_wrap;
   logic [31:0]        err_abs;
   logic signed [16:0] td_v;
   logic signed [18:0] d_v, lim_v;
   logic signed [14:0] steer_v;

   ssc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_point_index[IDX_W-1:0]),
      .wr_data (req_point_x),
      .rd_addr (rd_addr),
      .rd_data (rd_x)
   );

   ssc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_point_index[IDX_W-1:0]),
      .wr_data (req_point_y),
      .rd_addr (rd_addr),
      .rd_data (rd_y)
   );

   ssc_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram_h (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_point_index[IDX_W-1:0]),
      .wr_data (req_point_heading),
      .rd_addr (rd_addr),
      .rd_data (rd_h)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign wr_en     = req_fire && !req_mode && (32'(req_point_index) < 32'(MAX_POINTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      n_eff = (32'(path_points_ff) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                      : CNT_W'(path_points_ff);
      tgt_sel   = (last_target_ff >= best_idx_ff) ? last_target_ff : best_idx_ff;
      issue_en  = (state_ff == ST_SCAN) && (issue_ff < n_eff);
      scan_done = (issue_ff == n_eff) && !v1_ff && !v2_ff && !v3_ff;
      rd_addr   = (state_ff == ST_SCAN) ? issue_ff[IDX_W-1:0] : tgt_sel;

      hw_a   = 18'(req_pose_heading);
      hw_neg = 1'b0;
      if (hw_a > PI_Q13) begin
         hw_w = hw_a - TWO_PI_Q13;
      end else if (hw_a < -PI_Q13) begin
         hw_w = hw_a + TWO_PI_Q13;
      end else begin
         hw_w = hw_a;
      end
      if (hw_w > HALF_PI_Q13) begin
         hw_f   = hw_w - PI_Q13;
         hw_neg = 1'b1;
      end else if (hw_w < -HALF_PI_Q13) begin
         hw_f   = hw_w + PI_Q13;
         hw_neg = 1'b1;
      end else begin
         hw_f = hw_w;
      end

      if (rz_ff >= 0) begin
         rx_n = rx_ff - (ry_ff >>> step_ff);
         ry_n = ry_ff + (rx_ff >>> step_ff);
         rz_n = rz_ff - atan_entry(step_ff);
      end else begin
         rx_n = rx_ff + (ry_ff >>> step_ff);
         ry_n = ry_ff - (rx_ff >>> step_ff);
         rz_n = rz_ff + atan_entry(step_ff);
      end
      cos_v = neg_ff ? -rx_ff : rx_ff;
      sin_v = neg_ff ? -ry_ff : ry_ff;
      wb_s  = $signed({1'b0, wheelbase_ff});

      dx_v   = 33'(fx_ff) - 33'($signed(rd_x));
      dy_v   = 33'(fy_ff) - 33'($signed(rd_y));
      dist_v = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};

      err_diff = 54'(pxs_ff) - 54'(pyc_ff);
      hd_raw   = 18'($signed(rd_h)) - 18'(pose_hdg_ff);
      if (hd_raw > PI_Q13) begin
         hd_wrap = hd_raw - TWO_PI_Q13;
      end else if (hd_raw < -PI_Q13) begin
         hd_wrap = hd_raw + TWO_PI_Q13;
      end else begin
         hd_wrap = hd_raw;
      end
      err_abs = err_ff[31] ? 32'(-33'(err_ff)) : 32'(err_ff);

      if (vy_ff >= 0) begin
         vx_n = vx_ff + (vy_ff >>> step_ff);
         vy_n = vy_ff - (vx_ff >>> step_ff);
         vz_n = vz_ff + atan_entry(step_ff);
      end else begin
         vx_n = vx_ff - (vy_ff >>> step_ff);
         vy_n = vy_ff + (vx_ff >>> step_ff);
         vz_n = vz_ff - atan_entry(step_ff);
      end

      td_v  = err_ff[31] ? -td_mag_ff : td_mag_ff;
      d_v   = 19'(te_ff) + 19'(td_v);
      lim_v = (19'(limit_ff) > 19'(HALF_PI_Q13)) ? 19'(HALF_PI_Q13) : 19'(limit_ff);
      if (d_v > lim_v) begin
         steer_v = 15'(lim_v);
      end else if (d_v < -lim_v) begin
         steer_v = 15'(-lim_v);
      end else begin
         steer_v = 15'(d_v);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_mode) begin
               state_in = (n_eff == '0) ? ST_OUT : ST_ROT;
            end
         end
         ST_ROT: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_FRONT_MUL;
            end
         end
         ST_FRONT_MUL: state_in = ST_FRONT_ADD;
         ST_FRONT_ADD: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_ERR_MUL;
            end
         end
         ST_ERR_MUL:  state_in = ST_ERR_SUB;
         ST_ERR_SUB:  state_in = ST_GAIN_MUL;
         ST_GAIN_MUL: state_in = ST_NORM;
         ST_NORM: begin
            if (ym_ff == '0 || xm_ff == '0) begin
               state_in = ST_OUT;
            end else if (((ym_ff | 48'(xm_ff)) >> 30) == '0) begin
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= 16'd768;
         wheelbase_ff   <= 24'd131072;
         speed_ff       <= 24'd786432;
         limit_ff       <= 14'd4289;
         path_points_ff <= 11'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEER_GAIN:    gain_ff        <= csr_wdata[15:0];
            CSR_WHEELBASE:     wheelbase_ff   <= csr_wdata;
            CSR_VEHICLE_SPEED: speed_ff       <= csr_wdata;
            CSR_STEER_LIMIT:   limit_ff       <= csr_wdata[13:0];
            CSR_PATH_POINTS:   path_points_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         last_target_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         empty_ff       <= 1'b0;
         step_ff        <= '0;
         issue_ff       <= '0;
         best_found_ff  <= 1'b0;
      end else begin
         v1_ff <= issue_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_mode) begin
                  empty_ff <= (n_eff == '0);
                  step_ff  <= '0;
               end
            end
            ST_ROT: step_ff <= step_ff + 1'b1;
            ST_FRONT_ADD: begin
               issue_ff      <= '0;
               best_found_ff <= 1'b0;
            end
            ST_SCAN: begin
               if (issue_en) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (v3_ff) begin
                  best_found_ff <= 1'b1;
               end
            end
            ST_ERR_SUB: last_target_ff <= tgt_ff;
            ST_NORM: step_ff <= '0;
            ST_VEC: step_ff <= step_ff + 1'b1;
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      i1_ff  <= issue_ff[IDX_W-1:0];
      i2_ff  <= i1_ff;
      dx2_ff <= dx_v;
      dy2_ff <= dy_v;
      ax2_ff <= dx_v[32] ? 32'(-dx_v) : 32'(dx_v);
      ay2_ff <= dy_v[32] ? 32'(-dy_v) : 32'(dy_v);
      i3_ff   <= i2_ff;
      dx3_ff  <= dx2_ff;
      dy3_ff  <= dy2_ff;
      sqx3_ff <= ax2_ff * ax2_ff;
      sqy3_ff <= ay2_ff * ay2_ff;
      case (state_ff)
         ST_IDLE: begin
            pose_x_ff   <= req_pose_x;
            pose_y_ff   <= req_pose_y;
            pose_hdg_ff <= req_pose_heading;
            rx_ff       <= CORDIC_GAIN_Q15;
            ry_ff       <= '0;
            rz_ff       <= ZW'(hw_f) <<< 3;
            neg_ff      <= hw_neg;
         end
         ST_ROT: begin
            rx_ff <= rx_n;
            ry_ff <= ry_n;
            rz_ff <= rz_n;
         end
         ST_FRONT_MUL: begin
            cos_ff <= cos_v;
            sin_ff <= sin_v;
            wbc_ff <= wb_s * cos_v;
            wbs_ff <= wb_s * sin_v;
         end
         ST_FRONT_ADD: begin
            fx_ff <= sat32(40'(pose_x_ff) + 40'(wbc_ff >>> 15));
            fy_ff <= sat32(40'(pose_y_ff) + 40'(wbs_ff >>> 15));
         end
         ST_SCAN: begin
            if (v3_ff && (!best_found_ff || dist_v < best_dist_ff)) begin
               best_dist_ff <= dist_v;
               best_idx_ff  <= i3_ff;
               bdx_ff       <= dx3_ff;
               bdy_ff       <= dy3_ff;
            end
         end
         ST_ERR_MUL: begin
            pxs_ff <= bdx_ff * sin_ff;
            pyc_ff <= bdy_ff * cos_ff;
            tgt_ff <= tgt_sel;
         end
         ST_ERR_SUB: begin
            err_ff <= sat32(40'(err_diff >>> 15));
            te_ff  <= hd_wrap;
         end
         ST_GAIN_MUL: begin
            ym_ff <= err_abs * gain_ff;
            xm_ff <= {speed_ff, 8'd0};
         end
         ST_NORM: begin
            if (ym_ff == '0) begin
               td_mag_ff <= '0;
            end else if (xm_ff == '0) begin
               td_mag_ff <= 17'(HALF_PI_Q13);
            end else if (((ym_ff | 48'(xm_ff)) >> 30) != '0) begin
               ym_ff <= ym_ff >> 1;
               xm_ff <= xm_ff >> 1;
            end else begin
               vx_ff <= $signed({2'b00, xm_ff});
               vy_ff <= $signed({2'b00, ym_ff[31:0]});
               vz_ff <= '0;
            end
         end
         ST_VEC: begin
            vx_ff     <= vx_n;
            vy_ff     <= vy_n;
            vz_ff     <= vz_n;
            td_mag_ff <= 17'((vz_n + 20'sd4) >>> 3);
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_steer_ff  <= empty_ff ? 15'sd0 : steer_v;
               rsp_target_ff <= empty_ff ? 10'd0 : 10'(tgt_ff);
               rsp_err_ff    <= empty_ff ? 32'sd0 : err_ff;
               rsp_status_ff <= empty_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_steer_angle       = rsp_steer_ff;
   assign rsp_target_index      = rsp_target_ff;
   assign rsp_cross_track_error = rsp_err_ff;
   assign rsp_status            = rsp_status_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("Result appeared without passing the output state.");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ({1'b0, i3_ff} < issue_ff))
      else $error("Scan pipeline holds an entry that was never issued.");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR_MUL) |-> (best_found_ff && ({1'b0, best_idx_ff} < n_eff)))
      else $error("Nearest point lies outside the searched path.");

   a_vec_x_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VEC) |-> !vx_ff[33])
      else $error("Vectoring x went negative.");

endmodule

`default_nettype wire

@@ rtl/ssc_ram.sv @@
`default_nettype none
// Generic single write port, single read port RAM with registered read data.
module ssc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the Stanley steering controller with a bit-exact predictor.
module tb_top
   import ssc_pkg::*;
();

   localparam int LIMIT_CYCLES = 2000000;
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 54;
   localparam int SETTLE       = 80;
   localparam longint ATAN_STEP [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct {
      logic signed [14:0] steer;
      logic [9:0]         tidx;
      logic signed [31:0] cte;
      logic               status;
   } steer_cmd_type;

   typedef struct {
      logic               mode;
      logic [9:0]         slot;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] ph;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [15:0] qh;
      int                 npts;
      bit                 typed;
      steer_cmd_type      want;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_mode = 0;
   logic [9:0] req_point_index = 0;
   logic signed [31:0] req_point_x = 0, req_point_y = 0, req_pose_x = 0, req_pose_y = 0;
   logic signed [15:0] req_point_heading = 0, req_pose_heading = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [14:0] rsp_steer_angle;
   logic [9:0] rsp_target_index;
   logic signed [31:0] rsp_cross_track_error;
   logic rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [23:0] csr_wdata = 0;

   stanley_steering_controller_unit uut (.*);

   always #1 clock = ~clock;

   logic signed [31:0] path_x [MAX_POINTS];
   logic signed [31:0] path_y [MAX_POINTS];
   logic signed [15:0] path_h [MAX_POINTS];
   longint last_tgt;
   longint gain_r, wb_r, speed_r, limit_r, npts_r;

   steer_cmd_type pending_cmds [$];
   int errors = 0, cycles = 0, n_loads = 0, n_queries = 0, n_results = 0, stall_left = 0;
   int filled = 0;
   bit calm = 0;

   function automatic longint wrap_angle(input longint a);
      while (a > longint'(PI_Q13)) a -= longint'(TWO_PI_Q13);
      while (a < -longint'(PI_Q13)) a += longint'(TWO_PI_Q13);
      return a;
   endfunction

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void axle_sin_cos(input longint ang, output longint c, output longint s);
      longint a, x, y, z, nx;
      bit neg;
      a = wrap_angle(ang);
      neg = 0;
      if (a > longint'(HALF_PI_Q13)) begin
         a -= longint'(PI_Q13);
         neg = 1;
      end else if (a < -longint'(HALF_PI_Q13)) begin
         a += longint'(PI_Q13);
         neg = 1;
      end
      x = 19898;
      y = 0;
      z = a * 8;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_STEP[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_STEP[i];
         end
         x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint track_gain_angle(input longint err);
      bit [63:0] ym, xm;
      longint x, y, z, nx, r;
      ym = (err < 0 ? -err : err) * gain_r;
      xm = speed_r << 8;
      z = 0;
      if (ym == 0) return 0;
      if (xm == 0) begin
         r = longint'(HALF_PI_Q13);
      end else begin
         while ((ym | xm) >= 64'h40000000) begin
            ym >>= 1;
            xm >>= 1;
         end
         x = longint'(xm);
         y = longint'(ym);
         for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += ATAN_STEP[i];
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= ATAN_STEP[i];
            end
            x = nx;
         end
         r = (z + 4) >>> 3;
      end
      return err < 0 ? -r : r;
   endfunction

   function automatic bit steer_predict(input stim_row_type it, output steer_cmd_type res);
      longint n, c, s, fx, fy, dx, dy, bdx, bdy, err, idx, te, d, lim, best;
      bit [63:0] ax, ay, lo, sq, blo;
      bit hi, bhi;
      res.steer = '0;
      res.tidx = '0;
      res.cte = '0;
      res.status = 1'b0;
      if (it.mode == 1'b0) begin
         path_x[it.slot] = it.px;
         path_y[it.slot] = it.py;
         path_h[it.slot] = it.ph;
         return 0;
      end
      n = npts_r > MAX_POINTS ? MAX_POINTS : npts_r;
      if (n == 0) begin
         res.status = 1'b1;
         return 1;
      end
      axle_sin_cos(longint'(it.qh), c, s);
      fx = sat_word(longint'(it.qx) + ((wb_r * c) >>> 15));
      fy = sat_word(longint'(it.qy) + ((wb_r * s) >>> 15));
      best = 0; bdx = 0; bdy = 0; blo = 0; bhi = 0;
      for (int i = 0; i < n; i++) begin
         dx = fx - longint'(path_x[i]);
         dy = fy - longint'(path_y[i]);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         lo = ax * ax;
         sq = ay * ay;
         hi = (lo + sq) < lo;
         lo = lo + sq;
         if (i == 0 || hi < bhi || (hi == bhi && lo < blo)) begin
            bhi = hi; blo = lo; best = i; bdx = dx; bdy = dy;
         end
      end
      err = sat_word((bdx * s - bdy * c) >>> 15);
      idx = best;
      if (last_tgt >= idx) idx = last_tgt;
      if (idx >= MAX_POINTS) idx = MAX_POINTS - 1;
      last_tgt = idx;
      te = wrap_angle(longint'(path_h[idx]) - longint'(it.qh));
      d = te + track_gain_angle(err);
      lim = limit_r > longint'(HALF_PI_Q13) ? longint'(HALF_PI_Q13) : limit_r;
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
      res.steer = d[14:0];
      res.tidx = idx[9:0];
      res.cte = err[31:0];
      return 1;
   endfunction

   function automatic stim_row_type mk_row(input int mode, input int slot, input longint x,
                                           input longint y, input int h, input int npts,
                                           input bit typed);
      stim_row_type r;
      r.mode = 1'(mode); r.slot = 10'(slot); r.npts = npts; r.typed = typed;
      r.px = 32'(x); r.py = 32'(y); r.ph = 16'(h);
      r.qx = 32'(x); r.qy = 32'(y); r.qh = 16'(h);
      r.want.steer = '0;
      r.want.tidx = '0;
      r.want.cte = '0;
      r.want.status = typed;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_pos();
      if ($urandom_range(0, 3) != 0) begin
         return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      end
      return $urandom;
   endfunction

   function automatic logic [23:0] pick_reg(input int top);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return '0;
      if (r == 1) return 24'(top);
      return 24'($urandom_range(0, top));
   endfunction

   task automatic drive_item(input stim_row_type it);
      steer_cmd_type res;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= it.mode;
      req_point_index <= it.slot;
      req_point_x <= it.px;
      req_point_y <= it.py;
      req_point_heading <= it.ph;
      req_pose_x <= it.qx;
      req_pose_y <= it.qy;
      req_pose_heading <= it.qh;
      do @(posedge clock); while (req_stall);
      if (it.mode) n_queries++; else n_loads++;
      if (steer_predict(it, res)) begin
         pending_cmds.insert(pending_cmds.size(), it.typed ? it.want : res);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(input logic [2:0] ids [$], input logic [23:0] vals [$]);
      for (int i = 0; i < ids.size(); i++) begin
         csr_valid <= 1;
         csr_index <= ids[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (ids[i])
            CSR_STEER_GAIN:    gain_r = longint'(vals[i][15:0]);
            CSR_WHEELBASE:     wb_r = longint'(vals[i]);
            CSR_VEHICLE_SPEED: speed_r = longint'(vals[i]);
            CSR_STEER_LIMIT:   limit_r = longint'(vals[i][13:0]);
            CSR_PATH_POINTS:   npts_r = longint'(vals[i][10:0]);
            default: ;
         endcase
      end
      csr_valid <= 0;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      steer_cmd_type e;
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_cmds.size() == 0) begin
            $error("result transaction with no expectation pending");
            errors++;
         end else begin
            e = pending_cmds.pop_front();
            if (rsp_steer_angle !== e.steer) begin
               $error("steer_angle expected %0d actual %0d", e.steer, rsp_steer_angle);
               errors++;
            end
            if (rsp_target_index !== e.tidx) begin
               $error("target_index expected %0d actual %0d", e.tidx, rsp_target_index);
               errors++;
            end
            if (rsp_cross_track_error !== e.cte) begin
               $error("cross_track_error expected %0d actual %0d", e.cte,
                      rsp_cross_track_error);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type dir_rows [$];
      stim_row_type it;
      logic [2:0] ids [$];
      logic [23:0] vals [$];
      int cur_npts;

      gain_r = 768; wb_r = 131072; speed_r = 786432; limit_r = 4289; npts_r = 0;
      last_tgt = 0;
      cur_npts = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir_rows.insert(dir_rows.size(), mk_row(1, 0, 0, 0, 0, 0, 1));
      dir_rows.insert(dir_rows.size(),
                      mk_row(1, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'sd25736, 0, 1));
      dir_rows.insert(dir_rows.size(), mk_row(0, 0, 0, 0, 0, 0, 0));
      dir_rows.insert(dir_rows.size(),
                      mk_row(0, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF, 0, 0));
      dir_rows.insert(dir_rows.size(),
                      mk_row(0, 2, 32'sh80000000, 32'sh80000000, 16'sh8000, 0, 0));
      dir_rows.insert(dir_rows.size(), mk_row(0, 3, 65536, -65536, 16'sd12868, 0, 0));
      dir_rows.insert(dir_rows.size(),
                      mk_row(0, 1023, 32'sh5A5A5A5A, 32'shA5A5A5A5, 16'sh1234, 0, 0));
      dir_rows.insert(dir_rows.size(), mk_row(1, 0, 0, 0, 0, 1, 0));
      dir_rows.insert(dir_rows.size(),
                      mk_row(1, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd25736, 4, 0));
      dir_rows.insert(dir_rows.size(),
                      mk_row(1, 0, 32'sh80000000, 32'sh80000000, -16'sd25736, 4, 0));
      dir_rows.insert(dir_rows.size(), mk_row(1, 0, 0, 0, 16'sd12868, 4, 0));
      dir_rows.insert(dir_rows.size(), mk_row(1, 0, 196608, -65536, -16'sd12868, 4, 0));
      dir_rows.insert(dir_rows.size(), mk_row(1, 0, 65536, 65536, 16'sd100, 2, 0));
      dir_rows.insert(dir_rows.size(), mk_row(1, 0, 0, 0, 0, 0, 1));
      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode && dir_rows[i].npts != cur_npts) begin
            wait_idle();
            cur_npts = dir_rows[i].npts;
            ids = {CSR_PATH_POINTS};
            vals = {24'(cur_npts)};
            write_regs(ids, vals);
         end
         drive_item(dir_rows[i]);
      end
      filled = 4;

      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         ids = {CSR_STEER_GAIN, CSR_WHEELBASE, CSR_VEHICLE_SPEED, CSR_STEER_LIMIT,
                CSR_PATH_POINTS};
         case (p)
            0: vals = {24'd0, 24'd0, 24'd0, 24'd0, 24'd1};
            1: vals = {24'd65535, 24'hFFFFFF, 24'hFFFFFF, 24'd16383, 24'(filled)};
            2: vals = {pick_reg(65535), pick_reg(16777215), 24'd0, 24'd12868, 24'(filled)};
            3: vals = {24'd768, 24'd131072, 24'd786432, 24'd4289, 24'd0};
            default: vals = {pick_reg(65535), pick_reg(16777215), pick_reg(16777215),
                             pick_reg(16383),
                             24'($urandom_range(1, filled > 24 ? 24 : filled))};
         endcase
         write_regs(ids, vals);
         calm = (p == RAND_PHASES - 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            it = mk_row(1, 0, rand_pos(), rand_pos(), 0, 0, 0);
            it.qh = 16'($signed($urandom_range(0, 51472)) - 25736);
            it.px = rand_pos();
            it.py = rand_pos();
            it.ph = 16'($urandom);
            it.slot = 10'($urandom_range(0, filled));
            if ($urandom_range(0, 4) == 0) begin
               it.mode = 0;
               if (int'(it.slot) == filled) filled++;
            end else if ($urandom_range(0, 9) == 0) begin
               it.qx = $urandom;
               it.qy = $urandom;
            end
            drive_item(it);
         end
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (pending_cmds.size() != 0) begin
         $error("%0d expected results never arrived", pending_cmds.size());
         errors++;
      end
      $display("Ran %0d path loads and %0d pose queries, %0d results checked,", n_loads,
               n_queries, n_results);
      $display("over register extremes and empty paths, with random stalls and gaps.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ssc_pkg.sv
rtl/ssc_ram.sv
rtl/stanley_steering_controller_unit.sv
test/tb_top.sv
